/* rtl/core/i2c_target_byte_fsm_core_defines.svh */
// Assertion macros used by the I2C target byte sequencer top level.
`ifndef I2C_TARGET_BYTE_FSM_CORE_DEFINES_SVH
`define I2C_TARGET_BYTE_FSM_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define I2CTBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CTBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/i2ctbf_pkg.sv */
// Package: types, constants and helpers for the I2C target byte sequencer.
`timescale 1ns / 1ps
package i2ctbf_pkg;

  localparam int BUFFER_DEPTH = 32;
  localparam int BUF_AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FILL_W = $clog2(BUFFER_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > 6) ? FILL_W : 6;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] TX_START_FILL = 8'hFF;

  typedef enum logic [2:0] {
    CMD_START   = 3'd0,
    CMD_STOP    = 3'd1,
    CMD_SHIFT   = 3'd2,
    CMD_COLLIDE = 3'd3,
    CMD_BUF_RD  = 3'd4,
    CMD_BUF_WR  = 3'd5,
    CMD_SET_LEN = 3'd6
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEVICE_ADDR    = 2'd0,
    REG_BROADCAST_ADDR = 2'd1
  } cfg_reg_t;

  localparam logic [6:0] BCAST_ADDR_RST = 7'd9;

  typedef enum logic [6:0] {
    PH_WAIT   = 7'b0000001,
    PH_ADDR   = 7'b0000010,
    PH_SEND   = 7'b0000100,
    PH_REQACK = 7'b0001000,
    PH_CHKACK = 7'b0010000,
    PH_RECV   = 7'b0100000,
    PH_STORE  = 7'b1000000
  } phase_t;

  // Buffer port requests from the sequencer
  typedef struct packed {
    logic              we;
    logic [BUF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [BUF_AW-1:0] raddr;
  } ram_req_t;

  // Result fields known at accept; buffer data is merged as the item leaves stage one
  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_from_ram;
    logic       rd_from_ram;
    logic       next_bits;
    logic       sda_drive;
    logic [2:0] phase;
    logic       request_pending;
    logic [6:0] target_address;
    logic [5:0] buffer_count;
  } res_t;

  typedef struct packed {
    phase_t            phase;
    logic [FILL_W-1:0] fill;
    logic [FILL_W-1:0] send_pos;
  } stat_t;

  function automatic logic [2:0] phase_code(input phase_t ph);
    logic [2:0] c;
    case (ph)
      PH_WAIT:   c = 3'd0;
      PH_ADDR:   c = 3'd1;
      PH_SEND:   c = 3'd2;
      PH_REQACK: c = 3'd3;
      PH_CHKACK: c = 3'd4;
      PH_RECV:   c = 3'd5;
      PH_STORE:  c = 3'd6;
      default:   c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

/* rtl/core/i2c_target_byte_fsm_core.sv */
// I2C target (slave) byte-level sequencer: top level.
// Accepts one bus event or host command per clock while the stages have room.
// The result for an item is loaded into out_tdata when it leaves stage one: the
// sequencer updates its state and issues the buffer access at the accepting
// edge, the 32-byte buffer RAM registers its read data, and that data is merged
// into the result register as stage one advances. Two items can be in flight,
// so a stalled output side holds off the input only once both stages are full.
// The buffer is not cleared at reset; read only entries that have been written.
// Configuration writes are always taken (cfg_ready is tied high) and should be
// issued while no item is in flight.
`timescale 1ns / 1ps
`include "i2c_target_byte_fsm_core_defines.svh"
module i2c_target_byte_fsm_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [7:0] shifted_byte, [8] start_completed, [13:9] buffer_index,
  // [19:14] reply_length, [23:20] zero
  input  logic [i2ctbf_pkg::IN_DATA_W-1:0]    in_tdata,
  // [2:0] command
  input  logic [2:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [7:0] tx_byte, [8] next_bits, [9] sda_drive, [12:10] phase,
  // [13] request_pending, [20:14] target_address, [26:21] buffer_count,
  // [34:27] read_data, [39:35] zero
  output logic [i2ctbf_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [i2ctbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [6:0]                          cfg_data
);
  import i2ctbf_pkg::*;

  logic       in_accept;
  logic       s1_valid;
  logic [6:0] dev_addr_r, dev_addr_nxt;
  logic [6:0] bc_addr_r, bc_addr_nxt;
  ram_req_t   ram_req;
  res_t       res;
  stat_t      stat;
  logic [7:0] ram_rdata;

  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_comb begin
    dev_addr_nxt = dev_addr_r;
    bc_addr_nxt  = bc_addr_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEVICE_ADDR:    dev_addr_nxt = cfg_data;
        REG_BROADCAST_ADDR: bc_addr_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= 7'd0;
      bc_addr_r  <= BCAST_ADDR_RST;
    end else begin
      dev_addr_r <= dev_addr_nxt;
      bc_addr_r  <= bc_addr_nxt;
    end
  end

  i2ctbf_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (in_accept),
    .command           (in_tuser),
    .shifted_byte      (in_tdata[7:0]),
    .start_completed   (in_tdata[8]),
    .buffer_index      (in_tdata[13:9]),
    .reply_length      (in_tdata[19:14]),
    .device_address    (dev_addr_r),
    .broadcast_address (bc_addr_r),
    .ram_req           (ram_req),
    .res               (res),
    .stat              (stat)
  );

  i2ctbf_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH),
    .AW    (BUF_AW)
  ) u_buf (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  i2ctbf_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .res        (res),
    .ram_rdata  (ram_rdata),
    .in_ready   (in_tready),
    .s1_valid   (s1_valid),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `I2CTBF_ASSERT_NOW(a_fill_in_range, 1'b1, stat.fill <= FILL_W'(BUFFER_DEPTH), "fill beyond depth")
  `I2CTBF_ASSERT_NOW(a_pos_le_fill, 1'b1, stat.send_pos <= stat.fill, "send position past fill")
  `I2CTBF_ASSERT_NOW(a_no_overrun, s1_valid && out_tvalid && !out_tready, !in_tready, "stage overrun")
  `I2CTBF_ASSERT_NEXT(a_start_addr, in_accept && in_tuser == CMD_START && in_tdata[8], stat.phase == PH_ADDR, "start did not enter address check")

endmodule

/* rtl/core/i2ctbf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module i2ctbf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/i2ctbf_seq.sv */
// Bus-event sequencer: phase, fill, send position, address and request state.
`timescale 1ns / 1ps
module i2ctbf_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [2:0]          command,
  input  logic [7:0]          shifted_byte,
  input  logic                start_completed,
  input  logic [4:0]          buffer_index,
  input  logic [5:0]          reply_length,
  input  logic [6:0]          device_address,
  input  logic [6:0]          broadcast_address,
  output i2ctbf_pkg::ram_req_t ram_req,
  output i2ctbf_pkg::res_t    res,
  output i2ctbf_pkg::stat_t   stat
);
  import i2ctbf_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] pos_r, pos_nxt;
  logic [6:0]        addr_r, addr_nxt;
  logic              pend_r, pend_nxt;

  logic [CMP_W-1:0]  idx_ext, rlen_ext, fill_ext;
  logic [6:0]        seen_addr;
  logic              addr_hit;
  logic              do_load;
  logic [7:0]        tx;
  logic              tx_ram, rd_ram;

  assign idx_ext   = CMP_W'(buffer_index);
  assign rlen_ext  = CMP_W'(reply_length);
  assign seen_addr = shifted_byte[7:1];
  assign addr_hit  = (device_address != 7'd0 && seen_addr == device_address) ||
                     (broadcast_address != 7'd0 && seen_addr == broadcast_address);

  always_comb begin
    phase_nxt     = phase_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    addr_nxt      = addr_r;
    pend_nxt      = pend_r;
    ram_req       = '0;
    ram_req.wdata = shifted_byte;
    do_load       = 1'b0;
    tx            = 8'd0;
    tx_ram        = 1'b0;
    rd_ram        = 1'b0;

    case (cmd_t'(command))
      CMD_START: begin
        if (start_completed) begin
          phase_nxt = PH_ADDR;
          tx        = TX_START_FILL;
        end else begin
          phase_nxt = PH_WAIT;
        end
      end
      CMD_STOP: begin
        if (phase_r == PH_STORE) begin
          pend_nxt = 1'b1;
        end
        phase_nxt = PH_WAIT;
      end
      CMD_SHIFT: begin
        case (phase_r)
          PH_ADDR: begin
            addr_nxt = seen_addr;
            // read needs something to send; bit 0 is the direction
            if (addr_hit && (!shifted_byte[0] || fill_r != '0)) begin
              phase_nxt = shifted_byte[0] ? PH_SEND : PH_RECV;
            end else begin
              phase_nxt = PH_WAIT;
            end
          end
          PH_SEND:   do_load = 1'b1;
          PH_REQACK: phase_nxt = PH_CHKACK;
          PH_CHKACK: begin
            if (shifted_byte != 8'd0) begin
              phase_nxt = PH_WAIT;
            end else begin
              do_load = 1'b1;
            end
          end
          PH_RECV:   phase_nxt = PH_STORE;
          PH_STORE: begin
            if (fill_r < FILL_W'(BUFFER_DEPTH)) begin
              ram_req.we    = 1'b1;
              ram_req.waddr = fill_r[BUF_AW-1:0];
              fill_nxt      = fill_r + 1'b1;
            end
            phase_nxt = PH_RECV;
          end
          default: ;
        endcase
      end
      CMD_COLLIDE: begin
        if (phase_r == PH_SEND || phase_r == PH_REQACK || phase_r == PH_RECV) begin
          phase_nxt = PH_WAIT;
        end
      end
      CMD_BUF_RD: begin
        if (idx_ext < CMP_W'(BUFFER_DEPTH)) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = idx_ext[BUF_AW-1:0];
          rd_ram        = 1'b1;
        end
      end
      CMD_BUF_WR: begin
        if (idx_ext < CMP_W'(BUFFER_DEPTH)) begin
          ram_req.we    = 1'b1;
          ram_req.waddr = idx_ext[BUF_AW-1:0];
        end
      end
      CMD_SET_LEN: begin
        fill_nxt = (rlen_ext < CMP_W'(BUFFER_DEPTH)) ? rlen_ext[FILL_W-1:0]
                                                     : FILL_W'(BUFFER_DEPTH);
        pos_nxt  = '0;
        pend_nxt = 1'b0;
      end
      default: ;
    endcase

    // next reply byte, or zero once the reply is used up
    if (do_load) begin
      phase_nxt = PH_REQACK;
      if (pos_r < fill_r) begin
        ram_req.re    = 1'b1;
        ram_req.raddr = pos_r[BUF_AW-1:0];
        tx_ram        = 1'b1;
        pos_nxt       = pos_r + 1'b1;
      end
    end

    if (!accept) begin
      ram_req.we = 1'b0;
      ram_req.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      fill_r  <= '0;
      pos_r   <= '0;
      addr_r  <= 7'd0;
      pend_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      pos_r   <= pos_nxt;
      addr_r  <= addr_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign fill_ext = CMP_W'(fill_nxt);

  always_comb begin
    res.tx_byte         = tx;
    res.tx_from_ram     = tx_ram;
    res.rd_from_ram     = rd_ram;
    res.next_bits       = (phase_nxt == PH_SEND || phase_nxt == PH_CHKACK ||
                           phase_nxt == PH_RECV);
    res.sda_drive       = (phase_nxt == PH_SEND || phase_nxt == PH_REQACK ||
                           phase_nxt == PH_RECV);
    res.phase           = phase_code(phase_nxt);
    res.request_pending = pend_nxt;
    res.target_address  = addr_nxt;
    res.buffer_count    = fill_ext[5:0];
  end

  assign stat.phase    = phase_r;
  assign stat.fill     = fill_r;
  assign stat.send_pos = pos_r;

endmodule

/* rtl/core/i2ctbf_out.sv */
// Result stages: merges buffer read data and holds the item for the output side.
`timescale 1ns / 1ps
module i2ctbf_out (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  i2ctbf_pkg::res_t                     res,
  input  logic [7:0]                           ram_rdata,
  output logic                                 in_ready,
  output logic                                 s1_valid,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [i2ctbf_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import i2ctbf_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  res_t                  s1_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  s1_adv;
  logic [7:0]            tx_byte, read_data;

  // buffer data sits in the RAM output register while the item is in stage one
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_ready = !s1_valid_r || s1_adv;

  assign tx_byte   = s1_r.tx_from_ram ? ram_rdata : s1_r.tx_byte;
  assign read_data = s1_r.rd_from_ram ? ram_rdata : 8'd0;

  always_comb begin
    s1_valid_nxt  = accept || (s1_valid_r && !s1_adv);
    out_valid_nxt = s1_adv || (out_valid_r && !out_tready);
    out_data_nxt  = out_data_r;
    if (s1_adv) begin
      out_data_nxt = {5'd0, read_data, s1_r.buffer_count, s1_r.target_address,
                      s1_r.request_pending, s1_r.phase, s1_r.sda_drive,
                      s1_r.next_bits, tx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= res;
    end
    out_data_r <= out_data_nxt;
  end

  assign s1_valid   = s1_valid_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
